### rtl/emap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emap_pkg
// Shared types and constants of the event-to-pixel affine mapper.
// ----------------------------------------------------------------------------
package emap_pkg;

    localparam int COEF_W   = 32;
    localparam int WIDTH_W  = 14;
    localparam int HEIGHT_W = 13;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX      = 3'd0,
        REG_COEF_XY      = 3'd1,
        REG_COEF_YX      = 3'd2,
        REG_COEF_YY      = 3'd3,
        REG_TRANS_X      = 3'd4,
        REG_TRANS_Y      = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] coef_yx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] trans_x;
        logic signed [COEF_W-1:0] trans_y;
        logic [WIDTH_W-1:0]       frame_width;
        logic [HEIGHT_W-1:0]      frame_height;
    } cfg_t;

    typedef struct packed {
        logic polarity;
        logic last;
    } side_t;

endpackage

### rtl/emap_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emap_mult
// First stage: the four coefficient-by-coordinate products.
// ----------------------------------------------------------------------------
module emap_mult #(
    parameter int COORD_BITS = 12,
    parameter int PW         = 45
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  emap_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_BITS-1:0]  in_x,
    input  logic [COORD_BITS-1:0]  in_y,
    input  emap_pkg::side_t        in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [PW-1:0]   out_xx,
    output logic signed [PW-1:0]   out_xy,
    output logic signed [PW-1:0]   out_yx,
    output logic signed [PW-1:0]   out_yy,
    output emap_pkg::side_t        out_side
);
    import emap_pkg::*;

    logic                 valid_reg, valid_next;
    logic signed [PW-1:0] xx_reg, xy_reg, yx_reg, yy_reg;
    side_t                side_reg;
    logic signed [COORD_BITS:0] sx, sy;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign sx = $signed({1'b0, in_x});
    assign sy = $signed({1'b0, in_y});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            xx_reg   <= cfg.coef_xx * sx;
            xy_reg   <= cfg.coef_xy * sy;
            yx_reg   <= cfg.coef_yx * sx;
            yy_reg   <= cfg.coef_yy * sy;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_xx    = xx_reg;
    assign out_xy    = xy_reg;
    assign out_yx    = yx_reg;
    assign out_yy    = yy_reg;
    assign out_side  = side_reg;

endmodule

### rtl/emap_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emap_sum
// Second stage: product pair plus translation for each output axis.
// ----------------------------------------------------------------------------
module emap_sum #(
    parameter int PW = 45,
    parameter int SW = 47
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  emap_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [PW-1:0] in_xx,
    input  logic signed [PW-1:0] in_xy,
    input  logic signed [PW-1:0] in_yx,
    input  logic signed [PW-1:0] in_yy,
    input  emap_pkg::side_t      in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [SW-1:0] out_tx,
    output logic signed [SW-1:0] out_ty,
    output emap_pkg::side_t      out_side
);
    import emap_pkg::*;

    logic                 valid_reg, valid_next;
    logic signed [SW-1:0] tx_reg, ty_reg, tx_next, ty_next;
    side_t                side_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        tx_next = {{(SW-PW){in_xx[PW-1]}}, in_xx} + {{(SW-PW){in_xy[PW-1]}}, in_xy}
                + {{(SW-COEF_W){cfg.trans_x[COEF_W-1]}}, cfg.trans_x};
        ty_next = {{(SW-PW){in_yx[PW-1]}}, in_yx} + {{(SW-PW){in_yy[PW-1]}}, in_yy}
                + {{(SW-COEF_W){cfg.trans_y[COEF_W-1]}}, cfg.trans_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_tx    = tx_reg;
    assign out_ty    = ty_reg;
    assign out_side  = side_reg;

endmodule

### rtl/emap_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emap_round
// Third stage: round half up, bounds check against the frame, output register.
// ----------------------------------------------------------------------------
module emap_round #(
    parameter int SW         = 47,
    parameter int FRAC_BITS  = 16,
    parameter int FRAME_BITS = 13
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  emap_pkg::cfg_t          cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SW-1:0]    in_tx,
    input  logic signed [SW-1:0]    in_ty,
    input  emap_pkg::side_t         in_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [FRAME_BITS-1:0]   out_px,
    output logic [FRAME_BITS-2:0]   out_py,
    output logic                    out_on,
    output emap_pkg::side_t         out_side
);
    import emap_pkg::*;

    localparam int RW = SW + 1 - FRAC_BITS;

    logic                  valid_reg, valid_next;
    logic [FRAME_BITS-1:0] px_reg, px_next;
    logic [FRAME_BITS-2:0] py_reg, py_next;
    logic                  on_reg, on_next;
    side_t                 side_reg;

    logic [SW:0]   half;
    logic [SW:0]   ux, uy;
    logic [RW-1:0] rx, ry;
    logic [RW-1:0] wl, hl, wcap, hcap, wlim, hlim;

    always_comb begin
        half = {{SW{1'b0}}, 1'b1} << (FRAC_BITS - 1);
        ux   = {in_tx[SW-1], in_tx} + half;
        uy   = {in_ty[SW-1], in_ty} + half;
        rx   = ux[SW:FRAC_BITS];
        ry   = uy[SW:FRAC_BITS];
        wl   = {{(RW-WIDTH_W){1'b0}}, cfg.frame_width};
        hl   = {{(RW-HEIGHT_W){1'b0}}, cfg.frame_height};
        wcap = {{(RW-1){1'b0}}, 1'b1} << FRAME_BITS;
        hcap = {{(RW-1){1'b0}}, 1'b1} << (FRAME_BITS - 1);
        wlim = (wl > wcap) ? wcap : wl;
        hlim = (hl > hcap) ? hcap : hl;
        on_next = !rx[RW-1] && !ry[RW-1] && (rx < wlim) && (ry < hlim);
        px_next = on_next ? rx[FRAME_BITS-1:0] : '0;
        py_next = on_next ? ry[FRAME_BITS-2:0] : '0;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            on_reg   <= on_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_px    = px_reg;
    assign out_py    = py_reg;
    assign out_on    = on_reg;
    assign out_side  = side_reg;

endmodule

### rtl/event_to_pixel_affine_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_to_pixel_affine_mapper
// Maps sensor events to frame pixels through a 2x3 fixed-point affine
// transform with half-up rounding and a frame bounds check.
//
//   channel | direction | tdata                 | tuser               | tlast
//   s_      | in        | event_x, event_y      | polarity            | last_in_batch
//   m_      | out       | pixel_x, pixel_y      | on_frame, event_pol | batch_end
//   cfg_    | in        | write-only registers, index 0..7, 32-bit data
//
// One transfer per cycle sustained while m_tready is high; results pass
// through the three-stage pipeline (multiply, add, round and bounds check).
// Reset clears the pipeline valid bits and loads the identity transform
// and a 640 x 480 frame.
// A stall holds every stage whose successor is full; bubbles are absorbed.
// ----------------------------------------------------------------------------
module event_to_pixel_affine_mapper #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int FRAME_BITS = 13
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [emap_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [emap_pkg::COEF_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // event_x, event_y, zero padding
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // polarity
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, zero padding
    output logic [((2*FRAME_BITS-1+7)/8)*8-1:0] m_tdata,
    // on_frame, event_polarity
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import emap_pkg::*;

    localparam int PW = COEF_W + COORD_BITS + 1;
    localparam int SW = PW + 2;
    localparam int M_W = ((2*FRAME_BITS-1+7)/8)*8;

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_COEF_XX:      cfg_next.coef_xx      = cfg_wdata;
                REG_COEF_XY:      cfg_next.coef_xy      = cfg_wdata;
                REG_COEF_YX:      cfg_next.coef_yx      = cfg_wdata;
                REG_COEF_YY:      cfg_next.coef_yy      = cfg_wdata;
                REG_TRANS_X:      cfg_next.trans_x      = cfg_wdata;
                REG_TRANS_Y:      cfg_next.trans_y      = cfg_wdata;
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_wdata[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_wdata[HEIGHT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_xx      <= COEF_W'(1) << FRAC_BITS;
            cfg_reg.coef_xy      <= '0;
            cfg_reg.coef_yx      <= '0;
            cfg_reg.coef_yy      <= COEF_W'(1) << FRAC_BITS;
            cfg_reg.trans_x      <= '0;
            cfg_reg.trans_y      <= '0;
            cfg_reg.frame_width  <= WIDTH_W'(640);
            cfg_reg.frame_height <= HEIGHT_W'(480);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    side_t                s_side, mul_side, sum_side, out_side;
    logic                 mul_valid, mul_ready, sum_valid, sum_ready;
    logic signed [PW-1:0] p_xx, p_xy, p_yx, p_yy;
    logic signed [SW-1:0] t_x, t_y;
    logic [FRAME_BITS-1:0] pixel_x;
    logic [FRAME_BITS-2:0] pixel_y;
    logic                  on_frame;

    assign s_side.polarity = s_tuser[0];
    assign s_side.last     = s_tlast;

    emap_mult #(.COORD_BITS(COORD_BITS), .PW(PW)) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[COORD_BITS-1:0]),
        .in_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_side   (s_side),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_xx    (p_xx),
        .out_xy    (p_xy),
        .out_yx    (p_yx),
        .out_yy    (p_yy),
        .out_side  (mul_side)
    );

    emap_sum #(.PW(PW), .SW(SW)) u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_xx     (p_xx),
        .in_xy     (p_xy),
        .in_yx     (p_yx),
        .in_yy     (p_yy),
        .in_side   (mul_side),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_tx    (t_x),
        .out_ty    (t_y),
        .out_side  (sum_side)
    );

    emap_round #(.SW(SW), .FRAC_BITS(FRAC_BITS), .FRAME_BITS(FRAME_BITS)) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_tx     (t_x),
        .in_ty     (t_y),
        .in_side   (sum_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_px    (pixel_x),
        .out_py    (pixel_y),
        .out_on    (on_frame),
        .out_side  (out_side)
    );

    assign m_tdata = M_W'({pixel_y, pixel_x});
    assign m_tuser = {out_side.polarity, on_frame};
    assign m_tlast = out_side.last;

`ifndef SYNTHESIS
    a_off_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !on_frame |-> pixel_x == '0 && pixel_y == '0)
        else $error("off-frame result carries non-zero pixel");

    a_on_frame_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && on_frame |-> 32'(pixel_x) < 32'(cfg_reg.frame_width))
        else $error("on-frame column beyond frame width");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> mul_valid && sum_valid && m_tvalid && !m_tready)
        else $error("input blocked while pipeline has room");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !mul_valid && !sum_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

### tb/event_to_pixel_affine_mapper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_to_pixel_affine_mapper_test
// Self-checking bench for the event-to-pixel affine mapper. A short table of
// directed events (identity frame edges, exact halves, zero and oversized
// frames, coefficient extremes) is followed by random phases, each under a
// fresh register setting. Each accepted event gets its expected result from the
// table or a fixed-point model; each result is compared field by field, in order.
// ----------------------------------------------------------------------------
module event_to_pixel_affine_mapper_test;
    import emap_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int FRAME_BITS  = 13;
    localparam int ONE_Q       = 1 << FRAC_BITS;
    localparam int HALF_Q      = 1 << (FRAC_BITS - 1);
    localparam int MIN_Q       = 32'sh8000_0000;
    localparam int MAX_Q       = 32'sh7FFF_FFFF;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 161;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [COORD_BITS-1:0] ev_x;
        logic [COORD_BITS-1:0] ev_y;
        logic                  polarity;
        logic                  last_in_batch;
    } sensor_ev_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] pixel_x;
        logic [FRAME_BITS-2:0] pixel_y;
        logic                  on_frame;
        logic                  event_polarity;
        logic                  batch_end;
    } pixel_t;

    typedef struct {
        int         cfg_sel;
        sensor_ev_t ev;
        bit         typed;
        pixel_t     want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    cfg_t      map_cfg;
    cfg_t      dir_cfg[6];
    pixel_t    pending_pixels[$];
    stim_row_t stim_rows[$];
    int        errors = 0;
    int        n_items = 0;
    int        n_results = 0;
    int        n_on = 0;
    int        n_settings = 0;
    int        s_idle_pct = 6;
    int        m_idle_pct = 6;
    int        hold_seq = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    event_to_pixel_affine_mapper #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .FRAME_BITS(FRAME_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("event_to_pixel_affine_mapper_test failed");
        $finish;
    end

    function automatic cfg_t make_cfg(input int cxx, input int cxy, input int cyx,
                                      input int cyy, input int tx, input int ty,
                                      input int w, input int h);
        cfg_t c;
        c.coef_xx      = cxx;
        c.coef_xy      = cxy;
        c.coef_yx      = cyx;
        c.coef_yy      = cyy;
        c.trans_x      = tx;
        c.trans_y      = ty;
        c.frame_width  = w[WIDTH_W-1:0];
        c.frame_height = h[HEIGHT_W-1:0];
        return c;
    endfunction

    function automatic int rand_q(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // affine map, round half up, check against the clamped frame limits
    function automatic pixel_t map_to_pixel(input sensor_ev_t ev);
        longint tx, ty, px, py, wlim, hlim;
        bit     on;
        pixel_t r;
        tx = longint'($signed(map_cfg.coef_xx)) * longint'(ev.ev_x)
           + longint'($signed(map_cfg.coef_xy)) * longint'(ev.ev_y)
           + longint'($signed(map_cfg.trans_x));
        ty = longint'($signed(map_cfg.coef_yx)) * longint'(ev.ev_x)
           + longint'($signed(map_cfg.coef_yy)) * longint'(ev.ev_y)
           + longint'($signed(map_cfg.trans_y));
        px = (tx + HALF_Q) >>> FRAC_BITS;
        py = (ty + HALF_Q) >>> FRAC_BITS;
        wlim = longint'(map_cfg.frame_width);
        hlim = longint'(map_cfg.frame_height);
        if (wlim > (64'sd1 << FRAME_BITS)) wlim = 64'sd1 << FRAME_BITS;
        if (hlim > (64'sd1 << (FRAME_BITS - 1))) hlim = 64'sd1 << (FRAME_BITS - 1);
        on = px >= 0 && py >= 0 && px < wlim && py < hlim;
        r.pixel_x        = on ? px[FRAME_BITS-1:0] : '0;
        r.pixel_y        = on ? py[FRAME_BITS-2:0] : '0;
        r.on_frame       = on;
        r.event_polarity = ev.polarity;
        r.batch_end      = ev.last_in_batch;
        return r;
    endfunction

    task automatic add_row(input int sel, input int ex, input int ey, input bit pol,
                           input bit lst, input bit typed, input int px, input int py,
                           input bit on);
        stim_row_t r;
        r.cfg_sel                = sel;
        r.ev.ev_x                = ex[COORD_BITS-1:0];
        r.ev.ev_y                = ey[COORD_BITS-1:0];
        r.ev.polarity            = pol;
        r.ev.last_in_batch       = lst;
        r.typed                  = typed;
        r.want.pixel_x           = px[FRAME_BITS-1:0];
        r.want.pixel_y           = py[FRAME_BITS-2:0];
        r.want.on_frame          = on;
        r.want.event_polarity    = pol;
        r.want.batch_end         = lst;
        stim_rows.push_back(r);
    endtask

    // write every register, one per cycle; the block must be idle
    task automatic apply_cfg(input cfg_t c);
        cfg_idx_t    idx;
        logic [31:0] wdata;
        idx = idx.first();
        do begin
            wdata = $urandom;
            case (idx)
                REG_COEF_XX:      wdata = c.coef_xx;
                REG_COEF_XY:      wdata = c.coef_xy;
                REG_COEF_YX:      wdata = c.coef_yx;
                REG_COEF_YY:      wdata = c.coef_yy;
                REG_TRANS_X:      wdata = c.trans_x;
                REG_TRANS_Y:      wdata = c.trans_y;
                REG_FRAME_WIDTH:  wdata[WIDTH_W-1:0] = c.frame_width;
                REG_FRAME_HEIGHT: wdata[HEIGHT_W-1:0] = c.frame_height;
                default: ;
            endcase
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= wdata;
            @(posedge aclk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_wr_en <= 1'b0;
        map_cfg = c;
        n_settings++;
    endtask

    task automatic send_event(input sensor_ev_t ev, input bit typed, input pixel_t want);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ev.ev_y, ev.ev_x};
        s_tuser  <= ev.polarity;
        s_tlast  <= ev.last_in_batch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(typed ? want : map_to_pixel(ev));
        n_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // result side: check each transfer, drive tready with idling and hold-off
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.pixel_x        = m_tdata[FRAME_BITS-1:0];
                got.pixel_y        = m_tdata[2*FRAME_BITS-2:FRAME_BITS];
                got.on_frame       = m_tuser[0];
                got.event_polarity = m_tuser[1];
                got.batch_end      = m_tlast;
                n_results++;
                if (got.on_frame === 1'b1) n_on++;
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result transfer: pixel_x %0d pixel_y %0d",
                           got.pixel_x, got.pixel_y);
                    errors++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.pixel_x !== want.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
                        errors++;
                    end
                    if (got.pixel_y !== want.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
                        errors++;
                    end
                    if (got.on_frame !== want.on_frame) begin
                        $error("on_frame: expected %0d, got %0d", want.on_frame, got.on_frame);
                        errors++;
                    end
                    if (got.event_polarity !== want.event_polarity) begin
                        $error("event_polarity: expected %0d, got %0d",
                               want.event_polarity, got.event_polarity);
                        errors++;
                    end
                    if (got.batch_end !== want.batch_end) begin
                        $error("batch_end: expected %0d, got %0d", want.batch_end,
                               got.batch_end);
                        errors++;
                    end
                end
            end
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    initial begin
        int         cur;
        cfg_t       c;
        sensor_ev_t ev;
        pixel_t     none;

        none = '0;
        map_cfg = make_cfg(ONE_Q, 0, 0, ONE_Q, 0, 0, 640, 480);
        dir_cfg[0] = map_cfg;
        dir_cfg[1] = make_cfg(HALF_Q, 0, 0, HALF_Q, -HALF_Q, 0, 640, 480);
        dir_cfg[2] = make_cfg(ONE_Q, 0, 0, ONE_Q, 0, 0, 0, 0);
        dir_cfg[3] = make_cfg(2 * ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q, ONE_Q, 16383, 8191);
        dir_cfg[4] = make_cfg(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 8192, 4096);
        dir_cfg[5] = make_cfg(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MIN_Q, MAX_Q, 8192, 4096);

        // identity after reset: frame corners and edges
        add_row(0, 0, 0, 0, 0, 1, 0, 0, 1);
        add_row(0, 639, 479, 1, 1, 1, 639, 479, 1);
        add_row(0, 640, 0, 0, 1, 1, 0, 0, 0);
        add_row(0, 0, 480, 1, 0, 1, 0, 0, 0);
        add_row(0, 4095, 4095, 1, 0, 1, 0, 0, 0);
        add_row(0, 100, 200, 0, 1, 1, 100, 200, 1);
        // exact halves round up, minus a half becomes zero
        add_row(1, 0, 0, 1, 0, 1, 0, 0, 1);
        add_row(1, 2, 1, 0, 0, 1, 1, 1, 1);
        add_row(1, 1, 3, 1, 1, 1, 0, 2, 1);
        // zero frame size
        add_row(2, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(2, 300, 200, 1, 1, 1, 0, 0, 0);
        // oversized frame clipped to the field ranges
        add_row(3, 4095, 0, 1, 0, 1, 8191, 1, 1);
        add_row(3, 4095, 1, 0, 1, 1, 0, 0, 0);
        add_row(3, 0, 4094, 1, 1, 1, 4095, 4095, 1);
        add_row(3, 0, 4095, 0, 0, 1, 0, 0, 0);
        // coefficient extremes
        add_row(4, 4095, 4095, 1, 1, 0, 0, 0, 0);
        add_row(4, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(5, 4095, 0, 1, 0, 0, 0, 0, 0);
        add_row(5, 0, 4095, 0, 1, 0, 0, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        cur = 0;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].cfg_sel != cur) begin
                drain_results();
                cur = stim_rows[i].cfg_sel;
                apply_cfg(dir_cfg[cur]);
            end
            send_event(stim_rows[i].ev, stim_rows[i].typed, stim_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            case (p)
                0: c = dir_cfg[4];
                1: c = make_cfg(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, 16383, 8191);
                2: c = make_cfg(rand_q(2 * ONE_Q), rand_q(ONE_Q), rand_q(ONE_Q),
                                rand_q(2 * ONE_Q), rand_q(1 << 27), rand_q(1 << 27), 0, 0);
                3: c = make_cfg(rand_q(4) * HALF_Q, rand_q(4) * HALF_Q, rand_q(4) * HALF_Q,
                                rand_q(4) * HALF_Q, rand_q(2048) * HALF_Q,
                                rand_q(2048) * HALF_Q, $urandom_range(1, 8192),
                                $urandom_range(1, 4096));
                4: c = make_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom_range(0, 16383), $urandom_range(0, 8191));
                6: c = make_cfg(0, 0, 0, 0, rand_q(ONE_Q), rand_q(ONE_Q), 1, 1);
                default: c = make_cfg(rand_q(2 * ONE_Q), rand_q(ONE_Q), rand_q(ONE_Q),
                                      rand_q(2 * ONE_Q), rand_q(1 << 27), rand_q(1 << 27),
                                      $urandom_range(1, 8192), $urandom_range(1, 4096));
            endcase
            apply_cfg(c);
            s_idle_pct = (p == 5) ? 0 : 6;
            m_idle_pct <= (p == 5) ? 0 : 6;
            if (p == 6) hold_seq <= hold_seq + 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                ev.ev_x = COORD_BITS'(($urandom_range(9) == 0)
                                      ? ($urandom_range(1) ? 4095 : 0)
                                      : $urandom_range(4095));
                ev.ev_y = COORD_BITS'(($urandom_range(9) == 0)
                                      ? ($urandom_range(1) ? 4095 : 0)
                                      : $urandom_range(4095));
                ev.polarity      = 1'($urandom_range(1));
                ev.last_in_batch = ($urandom_range(15) == 0);
                send_event(ev, 1'b0, none);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);

        $display("Mapped %0d events under %0d register settings, including hold-off and",
                 n_items, n_settings + 1);
        $display("back-to-back stretches; %0d of %0d results landed on the frame.",
                 n_on, n_results);
        if (errors == 0) begin
            $display("event_to_pixel_affine_mapper_test passed");
        end else begin
            $display("event_to_pixel_affine_mapper_test failed");
        end
        $finish;
    end

endmodule
